[sv/adsu_pkg.sv]
`default_nettype none

package adsu_pkg;

    localparam int NUM_LINES = 4;

    // register map
    localparam logic [2:0] REG_RANGE_LINE0     = 3'd0;
    localparam logic [2:0] REG_RANGE_LINE1     = 3'd1;
    localparam logic [2:0] REG_RANGE_LINE2     = 3'd2;
    localparam logic [2:0] REG_RANGE_LINE3     = 3'd3;
    localparam logic [2:0] REG_POINTS_PER_LINE = 3'd4;

    // range codes (bit 2 set means line off)
    localparam logic [1:0] RANGE_8192 = 2'd0;
    localparam logic [1:0] RANGE_4096 = 2'd1;
    localparam logic [1:0] RANGE_2048 = 2'd2;
    localparam logic [1:0] RANGE_1024 = 2'd3;

    localparam logic [2:0]  RANGE_RESET = 3'd0;
    localparam logic [17:0] PPL_RESET   = 18'd1024;

    localparam logic signed [27:0] STEP_UV_MIN = 28'sd500;
    localparam logic signed [27:0] SAT_LEVEL   = 28'sd100000000;

    typedef struct packed {
        logic [12:0] raw_code;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]         slot_index;
        logic [16:0]        point_index;
        logic [16:0]        buffer_address;
        logic signed [27:0] sample_value;
        logic               overload;
        logic               frame_overload;
        logic               last;
    } out_beat_t;

    typedef struct packed {
        logic [2:0]  index;
        logic [17:0] data;
    } cfg_beat_t;

    typedef struct packed {
        logic [2:0]                  nlines;
        logic [NUM_LINES-1:0][1:0]   slot_range;
    } cfg_view_t;

endpackage

`default_nettype wire

[sv/adsu_stream_if.sv]
`default_nettype none

interface adsu_stream_if #(
    parameter type beat_t = logic
);
    logic  valid;
    logic  ready;
    beat_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[sv/adsu_cfg_regs.sv]
`default_nettype none

module adsu_cfg_regs #(
    parameter int MAX_POINTS = 131072,
    localparam int EW = $clog2(MAX_POINTS + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    adsu_stream_if.sink         cfg,
    output adsu_pkg::cfg_view_t view,
    output logic [EW-1:0]       eff,
    output logic                frame_clear
);
    import adsu_pkg::*;

    localparam int CW = (EW > 18) ? EW : 18;
    localparam logic [CW-1:0] CAP1 = CW'(MAX_POINTS);
    localparam logic [CW-1:0] CAP2 = CW'(MAX_POINTS / 2);
    localparam logic [CW-1:0] CAP3 = CW'(MAX_POINTS / 3);
    localparam logic [CW-1:0] CAP4 = CW'(MAX_POINTS / 4);

    logic [NUM_LINES-1:0][2:0] range_reg;
    logic [17:0]               ppl_reg;
    logic                      wr;
    logic [2:0]                line_cnt;
    logic [NUM_LINES-1:0][1:0] slot_range;
    logic [CW-1:0]             ppl_min;
    logic [CW-1:0]             cap;

    cfg_beat_t beat;

    assign beat        = cfg.payload;
    assign cfg.ready   = 1'b1;
    assign wr          = cfg.valid && cfg.ready;
    assign frame_clear = wr && (beat.index <= REG_POINTS_PER_LINE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_reg <= {NUM_LINES{RANGE_RESET}};
            ppl_reg   <= PPL_RESET;
        end
        else if (wr)
        begin
            if (beat.index < REG_POINTS_PER_LINE)
            begin
                range_reg[beat.index[1:0]] <= beat.data[2:0];
            end
            else if (beat.index == REG_POINTS_PER_LINE)
            begin
                ppl_reg <= beat.data;
            end
        end
    end

    // pack active lines into slots, in line order
    always_comb
    begin
        line_cnt   = '0;
        slot_range = '0;
        for (int i = 0; i < NUM_LINES; i++)
        begin
            if (!range_reg[i][2])
            begin
                slot_range[line_cnt[1:0]] = range_reg[i][1:0];
                line_cnt = line_cnt + 3'd1;
            end
        end
    end

    assign view.nlines     = line_cnt;
    assign view.slot_range = slot_range;

    always_comb
    begin
        ppl_min = (ppl_reg == '0) ? CW'(1) : CW'(ppl_reg);
        unique case (line_cnt)
            3'd2:    cap = CAP2;
            3'd3:    cap = CAP3;
            3'd4:    cap = CAP4;
            default: cap = CAP1;
        endcase
        eff = (ppl_min > cap) ? cap[EW-1:0] : ppl_min[EW-1:0];
    end

endmodule

`default_nettype wire

[sv/adsu_scale.sv]
`default_nettype none

module adsu_scale (
    input  logic [12:0]        raw_code,
    input  logic [1:0]         range_code,
    output logic signed [27:0] value,
    output logic               overload
);
    import adsu_pkg::*;

    logic signed [11:0] diff;
    logic signed [27:0] diff_w;
    logic signed [27:0] base;
    logic signed [27:0] scaled;

    // offset binary minus midscale
    assign diff     = {~raw_code[11], raw_code[10:0]};
    assign diff_w   = {{16{diff[11]}}, diff};
    assign base     = diff_w * STEP_UV_MIN;
    assign overload = raw_code[12];

    always_comb
    begin
        unique case (range_code)
            RANGE_8192: scaled = base <<< 3;
            RANGE_4096: scaled = base <<< 2;
            RANGE_2048: scaled = base <<< 1;
            RANGE_1024: scaled = base;
            default:    scaled = base;
        endcase
        if (overload)
        begin
            value = raw_code[11] ? SAT_LEVEL : -SAT_LEVEL;
        end
        else
        begin
            value = scaled;
        end
    end

endmodule

`default_nettype wire

[sv/adsu_frame_seq.sv]
`default_nettype none

module adsu_frame_seq #(
    parameter int MAX_POINTS = 131072,
    localparam int EW = $clog2(MAX_POINTS + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          frame_clear,
    input  logic          step,
    input  logic          overload,
    input  logic [2:0]    nlines,
    input  logic [EW-1:0] eff,
    output logic [1:0]    slot,
    output logic [16:0]   point,
    output logic [16:0]   address,
    output logic          frame_overload,
    output logic          last
);
    localparam int PW = $clog2(MAX_POINTS);
    localparam int MW = ((EW > 17) ? EW : 17) + 2;

    logic [1:0]    slot_cnt_reg;
    logic [1:0]    slot_cnt_next;
    logic [PW-1:0] point_cnt_reg;
    logic [PW-1:0] point_cnt_next;
    logic          seen_reg;
    logic          seen_next;
    logic [1:0]    slot_c;
    logic [PW-1:0] point_c;
    logic [2:0]    slot_inc;
    logic [MW-1:0] eff_w;
    logic [MW-1:0] point_w;
    logic [MW-1:0] addr_w;

    assign slot_c  = ({1'b0, slot_cnt_reg} >= nlines) ? 2'd0 : slot_cnt_reg;
    assign point_c = (EW'(point_cnt_reg) >= eff) ? '0 : point_cnt_reg;
    assign last    = ({1'b0, slot_c} == nlines - 3'd1) && (EW'(point_c) == eff - EW'(1));
    assign slot_inc = {1'b0, slot_c} + 3'd1;

    assign frame_overload = seen_reg | overload;

    // slot * eff + point, slot is two bits
    assign eff_w   = MW'(eff);
    assign point_w = MW'(point_c);
    assign addr_w  = (slot_c[0] ? eff_w : '0) + (slot_c[1] ? (eff_w << 1) : '0) + point_w;
    assign address = addr_w[16:0];
    assign point   = point_w[16:0];
    assign slot    = slot_c;

    always_comb
    begin
        slot_cnt_next  = slot_cnt_reg;
        point_cnt_next = point_cnt_reg;
        seen_next      = seen_reg;
        if (frame_clear || (step && last))
        begin
            slot_cnt_next  = '0;
            point_cnt_next = '0;
            seen_next      = 1'b0;
        end
        else if (step)
        begin
            seen_next = frame_overload;
            if (slot_inc >= nlines)
            begin
                slot_cnt_next  = '0;
                point_cnt_next = point_c + PW'(1);
            end
            else
            begin
                slot_cnt_next  = slot_inc[1:0];
                point_cnt_next = point_c;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_cnt_reg  <= '0;
            point_cnt_reg <= '0;
            seen_reg      <= 1'b0;
        end
        else
        begin
            slot_cnt_reg  <= slot_cnt_next;
            point_cnt_reg <= point_cnt_next;
            seen_reg      <= seen_next;
        end
    end

`ifndef SYNTHESIS
    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        step && last |=> slot_cnt_reg == '0 && point_cnt_reg == '0 && !seen_reg)
        else $error("frame state not cleared after last beat");

    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nlines != 3'd0 |-> {1'b0, slot_cnt_reg} < nlines)
        else $error("slot counter beyond active lines");

    a_point_bound: assert property (@(posedge clk) disable iff (!rst_n)
        EW'(point_cnt_reg) < eff)
        else $error("point counter beyond effective points");
`endif

endmodule

`default_nettype wire

[sv/interleaved_adc_demux_scale_unit.sv]
// Each accepted input beat passes the input register, then the result register, on its way to dout.
// Throughput: 1 beat per cycle while dout does not stall; set by the input register and the result
// register, which hand over in the same cycle.
// Beats taken while no line is active are dropped and give no result.
// Reset (rst_n, async, active low) clears valids, frame counters and sets
// every line to range code 0 with 1024 points per line.
`default_nettype none

module interleaved_adc_demux_scale_unit #(
    parameter int MAX_POINTS = 131072
) (
    input  logic          clk,
    input  logic          rst_n,
    adsu_stream_if.sink   din,
    adsu_stream_if.source dout,
    adsu_stream_if.sink   cfg
);
    import adsu_pkg::*;

    localparam int EW = $clog2(MAX_POINTS + 1);

    cfg_view_t     view;
    logic [EW-1:0] eff;
    logic          frame_clear;

    logic          s1_valid_reg;
    logic          s1_valid_next;
    logic [12:0]   s1_code_reg;
    logic          res_valid_reg;
    logic          res_valid_next;
    out_beat_t     res_reg;
    out_beat_t     res_next;

    logic          active;
    logic          out_free;
    logic          s1_go;
    logic          step;
    logic          din_take;
    in_beat_t      din_beat;

    logic [1:0]         slot;
    logic [16:0]        point;
    logic [16:0]        address;
    logic               frame_overload;
    logic               last;
    logic signed [27:0] value;
    logic               overload;

    adsu_cfg_regs #(
        .MAX_POINTS (MAX_POINTS)
    ) u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .view        (view),
        .eff         (eff),
        .frame_clear (frame_clear)
    );

    adsu_frame_seq #(
        .MAX_POINTS (MAX_POINTS)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .frame_clear    (frame_clear),
        .step           (step),
        .overload       (overload),
        .nlines         (view.nlines),
        .eff            (eff),
        .slot           (slot),
        .point          (point),
        .address        (address),
        .frame_overload (frame_overload),
        .last           (last)
    );

    adsu_scale u_scale (
        .raw_code   (s1_code_reg),
        .range_code (view.slot_range[slot]),
        .value      (value),
        .overload   (overload)
    );

    assign din_beat  = din.payload;
    assign active    = (view.nlines != 3'd0);
    assign out_free  = !res_valid_reg || dout.ready;
    assign s1_go     = s1_valid_reg && (!active || out_free);
    assign step      = s1_go && active;
    assign din.ready = !s1_valid_reg || s1_go;
    assign din_take  = din.valid && din.ready;

    assign dout.valid   = res_valid_reg;
    assign dout.payload = res_reg;

    always_comb
    begin
        res_next.slot_index     = slot;
        res_next.point_index    = point;
        res_next.buffer_address = address;
        res_next.sample_value   = value;
        res_next.overload       = overload;
        res_next.frame_overload = frame_overload;
        res_next.last           = last;

        s1_valid_next = din_take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);

        if (step)
        begin
            res_valid_next = 1'b1;
        end
        else if (dout.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (din_take)
        begin
            s1_code_reg <= din_beat.raw_code;
        end
        if (step)
        begin
            res_reg <= res_next;
        end
    end

`ifndef SYNTHESIS
    a_fov_covers_ov: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.overload |-> res_reg.frame_overload)
        else $error("overloaded beat without frame overload");

    a_drop_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_go && !active |=> res_valid_reg == $past(res_valid_reg && !dout.ready))
        else $error("dropped beat produced a result");

    a_step_room: assert property (@(posedge clk) disable iff (!rst_n)
        step |-> out_free && s1_valid_reg)
        else $error("result register overwritten");
`endif

endmodule

`default_nettype wire

[verif/tb_interleaved_adc_demux_scale_unit.sv]
`timescale 1ns / 100ps

module tb_interleaved_adc_demux_scale_unit;
    import adsu_pkg::*;

    localparam int MAX_POINTS = 131072;

    localparam logic [2:0] RANGE_OFF   = 3'd4;
    localparam logic [2:0] RANGE_OFF_5 = 3'd5;
    localparam logic [2:0] RANGE_OFF_6 = 3'd6;
    localparam logic [2:0] RANGE_OFF_7 = 3'd7;

    localparam logic [2:0] REG_SPARE_LO = 3'd5;
    localparam logic [2:0] REG_SPARE    = 3'd7;

    logic clk;
    logic rst_n;

    adsu_stream_if #(.beat_t(in_beat_t))  din_if ();
    adsu_stream_if #(.beat_t(out_beat_t)) dout_if ();
    adsu_stream_if #(.beat_t(cfg_beat_t)) cfg_if ();

    interleaved_adc_demux_scale_unit #(
        .MAX_POINTS(MAX_POINTS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_if),
        .dout  (dout_if),
        .cfg   (cfg_if)
    );

    // shadow of the block's registers and frame state
    logic [2:0]  range_sh[NUM_LINES];
    logic [17:0] ppl_sh;
    logic [1:0]  slot_sh;
    logic [16:0] point_sh;
    logic        ovs_sh;

    out_beat_t pending_samples[$];
    int        mismatch_cnt;
    int        src_idle_pct;
    int        snk_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        dout_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            dout_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    function automatic int step_uv(input logic [1:0] r);
        case (r)
            RANGE_8192: return 4000;
            RANGE_4096: return 2000;
            RANGE_2048: return 1000;
            default:    return 500;
        endcase
    endfunction

    function automatic int active_lines();
        int n;
        n = 0;
        for (int i = 0; i < NUM_LINES; i++)
            if (!range_sh[i][2])
                n++;
        return n;
    endfunction

    function automatic int frame_points(input int nl);
        int eff;
        eff = int'(ppl_sh);
        if (eff < 1)
            eff = 1;
        if (eff > MAX_POINTS / nl)
            eff = MAX_POINTS / nl;
        return eff;
    endfunction

    function automatic void clear_frame();
        slot_sh  = '0;
        point_sh = '0;
        ovs_sh   = 1'b0;
    endfunction

    function automatic void apply_reg(input logic [2:0] idx, input logic [17:0] data);
        if (idx < REG_POINTS_PER_LINE)
        begin
            range_sh[idx[1:0]] = data[2:0];
            clear_frame();
        end
        else if (idx == REG_POINTS_PER_LINE)
        begin
            ppl_sh = data;
            clear_frame();
        end
    endfunction

    function automatic bit demux_scale(input logic [12:0] code, output out_beat_t res);
        int scale_of_slot[NUM_LINES];
        int nl;
        int eff;
        int slot;
        int point;
        int val;
        bit ov;
        bit fov;
        bit lst;
        nl = 0;
        res = '0;
        for (int i = 0; i < NUM_LINES; i++)
        begin
            if (!range_sh[i][2])
            begin
                scale_of_slot[nl] = step_uv(range_sh[i][1:0]);
                nl++;
            end
        end
        if (nl == 0)
            return 1'b0;
        eff   = frame_points(nl);
        slot  = int'(slot_sh);
        point = int'(point_sh);
        if (slot >= nl)
            slot = 0;
        if (point >= eff)
            point = 0;
        if (code[12])
        begin
            val = code[11] ? int'(SAT_LEVEL) : -int'(SAT_LEVEL);
            ov  = 1'b1;
        end
        else
        begin
            val = (int'(code[11:0]) - 2048) * scale_of_slot[slot];
            ov  = 1'b0;
        end
        fov = ovs_sh | ov;
        lst = (slot == nl - 1) && (point == eff - 1);
        res.slot_index     = 2'(slot);
        res.point_index    = 17'(point);
        res.buffer_address = 17'(slot * eff + point);
        res.sample_value   = 28'(val);
        res.overload       = ov;
        res.frame_overload = fov;
        res.last           = lst;
        if (lst)
            clear_frame();
        else
        begin
            slot++;
            if (slot >= nl)
            begin
                slot = 0;
                point++;
            end
            slot_sh  = 2'(slot);
            point_sh = 17'(point);
            ovs_sh   = fov;
        end
        return 1'b1;
    endfunction

    initial
    begin
        for (int i = 0; i < NUM_LINES; i++)
            range_sh[i] = RANGE_RESET;
        ppl_sh = PPL_RESET;
        clear_frame();
    end

    always @(posedge clk)
    begin
        out_beat_t want;
        out_beat_t got;
        if (rst_n)
        begin
            if (dout_if.valid && dout_if.ready)
            begin
                got = dout_if.payload;
                if (pending_samples.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: unexpected beat slot=%0d point=%0d addr=%0d val=%0d",
                                 $realtime, got.slot_index, got.point_index,
                                 got.buffer_address, got.sample_value);
                end
                else
                begin
                    want = pending_samples.pop_front();
                    if (got.slot_index !== want.slot_index
                        || got.point_index !== want.point_index
                        || got.buffer_address !== want.buffer_address
                        || got.sample_value !== want.sample_value
                        || got.overload !== want.overload
                        || got.frame_overload !== want.frame_overload
                        || got.last !== want.last)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                        begin
                            $write("%0t: exp slot=%0d point=%0d addr=%0d ",
                                   $realtime, want.slot_index, want.point_index,
                                   want.buffer_address);
                            $display("val=%0d ov=%b fov=%b last=%b",
                                     want.sample_value, want.overload,
                                     want.frame_overload, want.last);
                            $write("%0t: got slot=%0d point=%0d addr=%0d ",
                                   $realtime, got.slot_index, got.point_index,
                                   got.buffer_address);
                            $display("val=%0d ov=%b fov=%b last=%b",
                                     got.sample_value, got.overload,
                                     got.frame_overload, got.last);
                        end
                    end
                end
            end
            if (cfg_if.valid && cfg_if.ready)
                apply_reg(cfg_if.payload.index, cfg_if.payload.data);
            if (din_if.valid && din_if.ready)
                if (demux_scale(din_if.payload.raw_code, want))
                    pending_samples.push_back(want);
        end
    end

    // wait until the pipeline is empty, dropped beats included
    task automatic settle();
        din_if.valid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_word(input logic [12:0] code);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            din_if.valid <= 1'b0;
            @(posedge clk);
        end
        din_if.valid   <= 1'b1;
        din_if.payload <= code;
        do
            @(posedge clk);
        while (!(din_if.valid && din_if.ready));
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [17:0] data);
        settle();
        cfg_if.valid         <= 1'b1;
        cfg_if.payload.index <= idx;
        cfg_if.payload.data  <= data;
        do
            @(posedge clk);
        while (!(cfg_if.valid && cfg_if.ready));
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [12:0] rand_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return {1'b1, 12'($urandom)};
        if (r < 20)
            case ($urandom_range(0, 3))
                0:       return 13'h0000;
                1:       return 13'h0FFF;
                2:       return 13'h0800;
                default: return 13'h07FF;
            endcase
        return {1'b0, 12'($urandom)};
    endfunction

    function automatic logic [17:0] pick_points();
        int r;
        r = $urandom_range(0, 19);
        if (r < 13)
            return 18'($urandom_range(1, 6));
        if (r < 16)
            return 18'($urandom_range(7, 40));
        if (r == 16)
            return 18'd0;
        if (r == 17)
            return 18'd131072;
        if (r == 18)
            return 18'h3FFFF;
        return 18'($urandom);
    endfunction

    task automatic random_setting();
        logic [2:0] code;
        if ($urandom_range(0, 11) == 0)
        begin
            for (int k = 0; k < NUM_LINES; k++)
                write_reg(3'(k), 18'($urandom_range(RANGE_OFF, RANGE_OFF_7)));
        end
        else
        begin
            for (int k = 0; k < NUM_LINES; k++)
            begin
                if ($urandom_range(0, 1))
                begin
                    if ($urandom_range(0, 4) == 0)
                        code = 3'($urandom_range(RANGE_OFF, RANGE_OFF_7));
                    else
                        code = {1'b0, 2'($urandom_range(0, 3))};
                    write_reg(3'(k), {($urandom_range(0, 1) ? 15'($urandom) : 15'd0), code});
                end
            end
            if ($urandom_range(0, 1))
                write_reg(REG_POINTS_PER_LINE, pick_points());
            if ($urandom_range(0, 5) == 0)
                write_reg(3'($urandom_range(REG_SPARE_LO, REG_SPARE)), 18'($urandom));
        end
    endtask

    task automatic test_reset_defaults();
        logic [12:0] codes[6] = '{13'h0000, 13'h0FFF, 13'h07FF, 13'h1800, 13'h1000, 13'h0800};
        foreach (codes[i])
            send_word(codes[i]);
    endtask

    task automatic test_ranges_and_frames();
        write_reg(REG_RANGE_LINE0, 18'(RANGE_1024));
        write_reg(REG_RANGE_LINE1, 18'(RANGE_2048));
        write_reg(REG_RANGE_LINE2, 18'(RANGE_4096));
        write_reg(REG_RANGE_LINE3, 18'(RANGE_8192));
        write_reg(REG_POINTS_PER_LINE, 18'd1);
        repeat (4) send_word(13'h0FFF);
        repeat (3) send_word(13'h0000);
        send_word(13'h1800);
        // two lines left, zero points requested
        write_reg(REG_RANGE_LINE1, 18'(RANGE_OFF_6));
        write_reg(REG_RANGE_LINE3, 18'(RANGE_OFF));
        write_reg(REG_POINTS_PER_LINE, 18'd0);
        send_word(13'h0AAA);
        send_word(13'h1555);
        send_word(13'h0555);
        // unused index must not restart the frame
        write_reg(REG_SPARE, 18'h3FFFF);
        send_word(13'h0FFE);
    endtask

    task automatic test_no_active_line();
        write_reg(REG_RANGE_LINE0, 18'(RANGE_OFF_5));
        write_reg(REG_RANGE_LINE2, 18'(RANGE_OFF_7));
        send_word(13'h1FFF);
        send_word(13'h0000);
        send_word(13'h0ABC);
    endtask

    task automatic test_point_clamp();
        write_reg(REG_RANGE_LINE0, 18'(RANGE_1024));
        write_reg(REG_POINTS_PER_LINE, 18'h3FFFF);
        repeat (3) send_word(rand_code());
        write_reg(REG_POINTS_PER_LINE, 18'd131072);
        write_reg(REG_RANGE_LINE1, 18'(RANGE_8192));
        write_reg(REG_RANGE_LINE2, 18'(RANGE_2048));
        write_reg(REG_RANGE_LINE3, 18'(RANGE_4096));
        repeat (3) send_word(rand_code());
        write_reg(REG_RANGE_LINE1, 18'(RANGE_OFF));
        write_reg(REG_RANGE_LINE2, 18'(RANGE_OFF));
        write_reg(REG_RANGE_LINE3, 18'(RANGE_OFF));
        write_reg(REG_POINTS_PER_LINE, 18'd1);
        send_word(13'h1000);
        send_word(13'h0001);
    endtask

    task automatic test_random_traffic(input int src_pct, input int snk_pct, input int n_items);
        int sent;
        int nl;
        int chunk;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        sent = 0;
        while (sent < n_items)
        begin
            random_setting();
            nl = active_lines();
            if (nl == 0)
                chunk = $urandom_range(1, 4);
            else
            begin
                chunk = nl * frame_points(nl) * $urandom_range(1, 3) + $urandom_range(0, nl);
                if (chunk > 48)
                    chunk = $urandom_range(20, 48);
            end
            repeat (chunk) send_word(rand_code());
            if (nl != 0)
                sent += chunk;
        end
    endtask

    initial
    begin
        mismatch_cnt   = 0;
        src_idle_pct   = 0;
        snk_idle_pct   = 0;
        rst_n          <= 1'b0;
        din_if.valid   <= 1'b0;
        din_if.payload <= '0;
        cfg_if.valid   <= 1'b0;
        cfg_if.payload <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_ranges_and_frames();
        test_no_active_line();
        test_point_clamp();
        test_random_traffic(15, 58, 470);
        test_random_traffic(58, 15, 470);
        test_random_traffic(0, 0, 460);

        settle();
        repeat (8) @(posedge clk);
        if (mismatch_cnt == 0 && pending_samples.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
